FILE: hdl/mfq_pkg.sv
`timescale 1ns / 1ps
package mfq_pkg;

    localparam int LEVELS       = 8;
    localparam int LVL_W        = 3;
    localparam int MAX_BURST    = 500;
    localparam int MAX_PRIORITY = 50;
    localparam logic [9:0] QUANTUM_CAP = 10'd1023;

    localparam logic [0:0] CFG_QUANTUM_BASE = 1'b0;
    localparam logic [0:0] CFG_QUEUE_COUNT  = 1'b1;

    localparam logic [2:0] ST_IDLE_TICK = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_RAN       = 3'd4;
    localparam logic [2:0] ST_FINISHED  = 3'd5;
    localparam logic [2:0] ST_DEMOTED   = 3'd6;
    localparam logic [2:0] ST_REQUEUED  = 3'd7;

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_ADD_CHECK  = 4'd2;
    localparam logic [3:0] OP_ADD_SCAN   = 4'd3;
    localparam logic [3:0] OP_PUSH       = 4'd4;
    localparam logic [3:0] OP_TICK_START = 4'd5;
    localparam logic [3:0] OP_FRONT_READ = 4'd6;
    localparam logic [3:0] OP_FRONT_CMP  = 4'd7;
    localparam logic [3:0] OP_PICK       = 4'd8;
    localparam logic [3:0] OP_QUANT      = 4'd9;
    localparam logic [3:0] OP_RUN        = 4'd10;
    localparam logic [3:0] OP_OUT        = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } mfq_cmd_t;

    typedef struct packed {
        logic kind;
        logic invalid;
        logic scan_hit;
        logic running;
        logic scan_end;
        logic q_empty;
        logic found;
        logic front_zero;
        logic quant_done;
        logic expire;
        logic out_busy;
    } mfq_sts_t;

endpackage

FILE: hdl/mfq_ram.sv
`timescale 1ns / 1ps
module mfq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mfq_ctrl.sv
`timescale 1ns / 1ps
module mfq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mfq_pkg::mfq_sts_t sts,
    output mfq_pkg::mfq_cmd_t cmd
);
    import mfq_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_ADD_CHECK  = 4'd2;
    localparam logic [3:0] S_ADD_SCAN   = 4'd3;
    localparam logic [3:0] S_PUSH       = 4'd4;
    localparam logic [3:0] S_TICK_START = 4'd5;
    localparam logic [3:0] S_FRONT_READ = 4'd6;
    localparam logic [3:0] S_FRONT_CMP  = 4'd7;
    localparam logic [3:0] S_PICK       = 4'd8;
    localparam logic [3:0] S_QUANT      = 4'd9;
    localparam logic [3:0] S_RUN        = 4'd10;
    localparam logic [3:0] S_RESULT     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = sts.kind ? S_TICK_START : S_ADD_CHECK;
            end
            S_ADD_CHECK: begin
                cmd.op     = OP_ADD_CHECK;
                state_next = sts.invalid ? S_RESULT : S_ADD_SCAN;
            end
            S_ADD_SCAN: begin
                cmd.op = OP_ADD_SCAN;
                if (sts.scan_hit) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.op     = OP_PUSH;
                state_next = S_RESULT;
            end
            S_TICK_START: begin
                cmd.op     = OP_TICK_START;
                state_next = sts.running ? S_RUN : S_FRONT_READ;
            end
            S_FRONT_READ: begin
                cmd.op = OP_FRONT_READ;
                if (sts.scan_end) begin
                    state_next = S_PICK;
                end else if (!sts.q_empty) begin
                    state_next = S_FRONT_CMP;
                end
            end
            S_FRONT_CMP: begin
                cmd.op     = OP_FRONT_CMP;
                state_next = S_FRONT_READ;
            end
            S_PICK: begin
                cmd.op     = OP_PICK;
                state_next = (!sts.found || sts.front_zero) ? S_RESULT : S_QUANT;
            end
            S_QUANT: begin
                cmd.op = OP_QUANT;
                if (sts.quant_done) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                cmd.op     = OP_RUN;
                state_next = sts.expire ? S_PUSH : S_RESULT;
            end
            S_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/mfq_datapath.sv
`timescale 1ns / 1ps
module mfq_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfq_pkg::mfq_cmd_t cmd,
    output mfq_pkg::mfq_sts_t sts,
    input  logic [23:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_addr,
    input  logic [4:0]        cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata
);
    import mfq_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [4:0]  qb_reg;
    logic [3:0]  qc_reg;
    logic        kind_reg;
    logic [8:0]  burst_reg;
    logic [5:0]  pri_reg;
    logic [2:0]  rq_reg;
    logic [3:0]  idx_reg;
    logic [9:0]  qv_reg;
    logic [5:0]  best_reg;
    logic [2:0]  pick_reg;
    logic        found_reg;
    logic [17:0] job_reg;
    logic [2:0]  dest_reg;
    logic [8:0]  push_rem_reg;
    logic [5:0]  push_pri_reg;
    logic [2:0]  ok_status_reg;
    logic [2:0]  status_reg;
    logic [8:0]  cur_rem_reg;
    logic [5:0]  cur_pri_reg;
    logic [2:0]  cur_lvl_reg;
    logic [9:0]  slice_reg;
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic [4:0]  base_eff;
    logic [3:0]  n_eff;
    logic [14:0] prod;
    logic [9:0]  qv_mult;
    logic        push_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [17:0] wdata;
    logic [17:0] rdata;
    logic [8:0]  rem_dec;
    logic [9:0]  slice_dec;
    logic [2:0]  run_dest;
    logic        at_last;
    logic        run_valid;

    assign base_eff = (qb_reg == 5'd0) ? 5'd1 : qb_reg;
    assign n_eff    = (qc_reg == 4'd0) ? 4'd1 :
                      (qc_reg > 4'(LEVELS)) ? 4'(LEVELS) : qc_reg;
    assign prod     = {5'd0, qv_reg} * {10'd0, base_eff};
    assign qv_mult  = (prod > {5'd0, QUANTUM_CAP}) ? QUANTUM_CAP : prod[9:0];

    assign rem_dec   = cur_rem_reg - 9'd1;
    assign slice_dec = (slice_reg != 10'd0) ? slice_reg - 10'd1 : 10'd0;
    assign at_last   = ({1'b0, cur_lvl_reg} >= n_eff - 4'd1);
    assign run_dest  = at_last ? 3'(n_eff - 4'd1) : cur_lvl_reg + 3'd1;
    assign run_valid = (cur_rem_reg != 9'd0);

    assign push_we = (cmd.op == OP_PUSH) && (count_reg[dest_reg] < CNT_FULL);
    assign waddr   = {dest_reg, tail_reg[dest_reg]};
    assign wdata   = {dest_reg, push_pri_reg, push_rem_reg};
    assign raddr   = {idx_reg[2:0], head_reg[idx_reg[2:0]]};

    mfq_ram #(
        .WIDTH(18),
        .DEPTH(LEVELS * QUEUE_DEPTH)
    ) u_job_store (
        .aclk  (aclk),
        .we    (push_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        sts.kind       = kind_reg;
        sts.invalid    = (burst_reg < 9'd1) || (burst_reg > 9'(MAX_BURST)) ||
                         (pri_reg < 6'd1) || (pri_reg > 6'(MAX_PRIORITY));
        sts.scan_hit   = (qv_reg >= {4'd0, pri_reg}) || (idx_reg == n_eff - 4'd1);
        sts.running    = run_valid;
        sts.scan_end   = (idx_reg >= n_eff);
        sts.q_empty    = (count_reg[idx_reg[2:0]] == '0);
        sts.found      = found_reg;
        sts.front_zero = (job_reg[8:0] == 9'd0);
        sts.quant_done = (idx_reg[2:0] == cur_lvl_reg);
        sts.expire     = (rem_dec != 9'd0) && (slice_dec == 10'd0);
        sts.out_busy   = m_tvalid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            kind_reg  <= s_tuser;
            burst_reg <= s_tdata[8:0];
            pri_reg   <= s_tdata[14:9];
            rq_reg    <= s_tdata[17:15];
        end
        case (cmd.op)
            OP_ADD_CHECK: begin
                status_reg <= ST_INVALID;
                idx_reg    <= 4'd0;
                qv_reg     <= {5'd0, base_eff};
            end
            OP_ADD_SCAN: begin
                if (sts.scan_hit) begin
                    dest_reg      <= idx_reg[2:0];
                    push_rem_reg  <= burst_reg;
                    push_pri_reg  <= pri_reg;
                    ok_status_reg <= ST_ADDED;
                end else begin
                    qv_reg  <= qv_mult;
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            OP_PUSH: begin
                status_reg <= push_we ? ok_status_reg : ST_DROPPED;
            end
            OP_TICK_START: begin
                idx_reg  <= 4'd0;
                best_reg <= 6'(MAX_PRIORITY + 1);
                pick_reg <= 3'd0;
            end
            OP_FRONT_READ: begin
                if (!sts.scan_end && sts.q_empty) begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            OP_FRONT_CMP: begin
                if (rdata[14:9] < best_reg) begin
                    best_reg <= rdata[14:9];
                    pick_reg <= idx_reg[2:0];
                    job_reg  <= rdata;
                end
                idx_reg <= idx_reg + 4'd1;
            end
            OP_PICK: begin
                status_reg <= ST_IDLE_TICK;
                idx_reg    <= 4'd0;
                qv_reg     <= {5'd0, base_eff};
            end
            OP_QUANT: begin
                if (!sts.quant_done) begin
                    qv_reg  <= qv_mult;
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            OP_RUN: begin
                if (rem_dec == 9'd0) begin
                    status_reg <= ST_FINISHED;
                end else if (slice_dec == 10'd0) begin
                    dest_reg      <= run_dest;
                    push_rem_reg  <= rem_dec;
                    push_pri_reg  <= cur_pri_reg;
                    ok_status_reg <= at_last ? ST_REQUEUED : ST_DEMOTED;
                end else begin
                    status_reg <= ST_RAN;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qb_reg       <= 5'd2;
            qc_reg       <= 4'd4;
            found_reg    <= 1'b0;
            cur_rem_reg  <= 9'd0;
            cur_pri_reg  <= 6'd0;
            cur_lvl_reg  <= 3'd0;
            slice_reg    <= 10'd0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_QUANTUM_BASE: qb_reg <= cfg_wdata;
                    CFG_QUEUE_COUNT:  qc_reg <= cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            if (m_tvalid_reg && m_tready && cmd.op != OP_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_TICK_START: begin
                    found_reg <= 1'b0;
                end
                OP_FRONT_CMP: begin
                    if (rdata[14:9] < best_reg) begin
                        found_reg <= 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (push_we) begin
                        tail_reg[dest_reg]  <= (tail_reg[dest_reg] == PTR_LAST) ?
                                               '0 : tail_reg[dest_reg] + 1'b1;
                        count_reg[dest_reg] <= count_reg[dest_reg] + 1'b1;
                    end
                end
                OP_PICK: begin
                    if (found_reg) begin
                        head_reg[pick_reg]  <= (head_reg[pick_reg] == PTR_LAST) ?
                                               '0 : head_reg[pick_reg] + 1'b1;
                        count_reg[pick_reg] <= count_reg[pick_reg] - 1'b1;
                        if (job_reg[8:0] != 9'd0) begin
                            cur_rem_reg <= job_reg[8:0];
                            cur_pri_reg <= job_reg[14:9];
                            cur_lvl_reg <= job_reg[17:15];
                        end
                    end
                end
                OP_QUANT: begin
                    if (sts.quant_done) begin
                        slice_reg <= qv_reg;
                    end
                end
                OP_RUN: begin
                    if (rem_dec == 9'd0 || slice_dec == 10'd0) begin
                        cur_rem_reg <= 9'd0;
                        cur_pri_reg <= 6'd0;
                        cur_lvl_reg <= 3'd0;
                        slice_reg   <= 10'd0;
                    end else begin
                        cur_rem_reg <= rem_dec;
                        slice_reg   <= slice_dec;
                    end
                end
                OP_OUT: begin
                    m_tvalid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            m_tdata_reg <= {1'b0, 7'(count_reg[rq_reg]), slice_reg, cur_rem_reg,
                            cur_lvl_reg, cur_pri_reg, run_valid, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 1ps
// add request: the target level is found by the iterative quantum multiply
// tick request: steps through the queue front scan via the job store read port
// and the quantum multiply; one request in flight, next accepted once the result is queued
// reset clears config to defaults, queue pointers and counts, and the running job
// the job store is not cleared; only written entries are read
module multilevel_feedback_queue_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // burst_time, job_priority, report_queue, zero pad
    input  logic        s_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status, running_valid, running_priority, running_level,
                                   // running_remaining, slice_left, report_count, zero pad
);
    import mfq_pkg::*;

    mfq_cmd_t cmd;
    mfq_sts_t sts;

    assign cfg_ready = 1'b1;

    mfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/sv/mfq_checker.sv
`timescale 1ns / 1ps
module mfq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);
    import mfq_pkg::*;

    localparam int          DEPTH    = 64;
    localparam logic        KIND_ADD = 1'b0;

    typedef struct {
        logic [8:0] remaining;
        logic [5:0] priority_v;
        logic [2:0] level;
    } job_t;

    typedef struct {
        logic [2:0] status;
        logic       run_valid;
        logic [5:0] run_priority;
        logic [2:0] run_level;
        logic [8:0] run_remaining;
        logic [9:0] slice_left;
        logic [6:0] report_count;
    } sched_result_t;

    logic [4:0]    quantum_base;
    logic [3:0]    queue_count;
    job_t          lanes[LEVELS][$];
    job_t          running;
    int            slice_ctr;
    sched_result_t expected_q[$];

    function automatic int levels_used();
        if (queue_count == 0) return 1;
        if (queue_count > LEVELS) return LEVELS;
        return queue_count;
    endfunction

    function automatic int quantum(int lvl);
        int b;
        int q;
        b = (quantum_base == 0) ? 1 : quantum_base;
        q = 1;
        for (int i = 0; i <= lvl; i++) begin
            q = q * b;
            if (q > QUANTUM_CAP) return QUANTUM_CAP;
        end
        return q;
    endfunction

    function automatic bit enqueue(int q, job_t j);
        if (lanes[q].size() >= DEPTH) return 0;
        j.level = q;
        lanes[q].push_back(j);
        return 1;
    endfunction

    function automatic logic [2:0] predict_add(logic [8:0] burst, logic [5:0] pri);
        int   n;
        int   q;
        job_t j;
        n = levels_used();
        q = n - 1;
        if (burst < 1 || burst > MAX_BURST || pri < 1 || pri > MAX_PRIORITY)
            return ST_INVALID;
        for (int i = 0; i < n; i++) begin
            if (quantum(i) >= pri) begin
                q = i;
                break;
            end
        end
        j.remaining = burst;
        j.priority_v = pri;
        return enqueue(q, j) ? ST_ADDED : ST_DROPPED;
    endfunction

    function automatic logic [2:0] predict_tick();
        int         n;
        int         best;
        int         pick;
        int         dest;
        logic [2:0] st;
        n = levels_used();
        if (running.remaining == 0) begin
            best = MAX_PRIORITY + 1;
            pick = -1;
            for (int i = 0; i < n; i++) begin
                if (lanes[i].size() != 0 && lanes[i][0].priority_v < best) begin
                    best = lanes[i][0].priority_v;
                    pick = i;
                end
            end
            if (pick < 0) return ST_IDLE_TICK;
            running = lanes[pick].pop_front();
            slice_ctr = quantum(running.level);
        end
        running.remaining--;
        if (slice_ctr != 0) slice_ctr--;
        if (running.remaining == 0) begin
            st = ST_FINISHED;
        end else if (slice_ctr == 0) begin
            if (running.level < n - 1) begin
                dest = running.level + 1;
                st = ST_DEMOTED;
            end else begin
                dest = n - 1;
                st = ST_REQUEUED;
            end
            if (!enqueue(dest, running)) st = ST_DROPPED;
        end else begin
            return ST_RAN;
        end
        running = '{default: '0};
        slice_ctr = 0;
        return st;
    endfunction

    always @(posedge aclk) begin
        sched_result_t r;
        sched_result_t e;
        logic [2:0]    rq;
        if (!aresetn) begin
            quantum_base <= 5'd2;
            queue_count  <= 4'd4;
            foreach (lanes[i]) lanes[i].delete();
            running = '{default: '0};
            slice_ctr = 0;
            expected_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                r.status        = m_tdata[2:0];
                r.run_valid     = m_tdata[3];
                r.run_priority  = m_tdata[9:4];
                r.run_level     = m_tdata[12:10];
                r.run_remaining = m_tdata[21:13];
                r.slice_left    = m_tdata[31:22];
                r.report_count  = m_tdata[38:32];
                if (expected_q.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    mismatches++;
                end else begin
                    e = expected_q.pop_front();
                    if (r.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, r.status);
                        mismatches++;
                    end
                    if (r.run_valid !== e.run_valid) begin
                        $error("running_valid exp %0d got %0d", e.run_valid, r.run_valid);
                        mismatches++;
                    end
                    if (r.run_priority !== e.run_priority) begin
                        $error("running_priority exp %0d got %0d",
                               e.run_priority, r.run_priority);
                        mismatches++;
                    end
                    if (r.run_level !== e.run_level) begin
                        $error("running_level exp %0d got %0d", e.run_level, r.run_level);
                        mismatches++;
                    end
                    if (r.run_remaining !== e.run_remaining) begin
                        $error("running_remaining exp %0d got %0d",
                               e.run_remaining, r.run_remaining);
                        mismatches++;
                    end
                    if (r.slice_left !== e.slice_left) begin
                        $error("slice_left exp %0d got %0d", e.slice_left, r.slice_left);
                        mismatches++;
                    end
                    if (r.report_count !== e.report_count) begin
                        $error("report_count exp %0d got %0d",
                               e.report_count, r.report_count);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == CFG_QUANTUM_BASE) quantum_base <= cfg_wdata;
                else queue_count <= cfg_wdata[3:0];
            end
            if (s_tvalid && s_tready) begin
                rq = s_tdata[17:15];
                if (s_tuser == KIND_ADD) e.status = predict_add(s_tdata[8:0], s_tdata[14:9]);
                else e.status = predict_tick();
                e.run_valid     = running.remaining != 0;
                e.run_priority  = e.run_valid ? running.priority_v : '0;
                e.run_level     = e.run_valid ? running.level : '0;
                e.run_remaining = running.remaining;
                e.slice_left    = e.run_valid ? slice_ctr[9:0] : '0;
                e.report_count  = 7'(lanes[rq].size());
                expected_q.push_back(e);
            end
            outstanding <= expected_q.size();
        end
    end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mfq_pkg::*;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_addr = '0;
    logic [4:0]  cfg_wdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    int          mismatches;
    int          outstanding;
    bit          quiet = 0;
    int          stall_left = 0;

    always #2 aclk = ~aclk;

    multilevel_feedback_queue_scheduler uut (.*);

    mfq_checker checker_i (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            stall_left <= pick_gap();
        end
    end

    task automatic send(logic kind, int burst, int pri, int rq);
        int gap;
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, 3'(rq), 6'(pri), 9'(burst)};
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [0:0] idx, int val);
        cfg_valid <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= 5'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic random_add();
        int b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) b = $urandom_range(1, 8);
        else if (r < 95) b = $urandom_range(9, 60);
        else b = $urandom_range(400, MAX_BURST);
        if ($urandom_range(0, 9) == 0)
            send(KIND_ADD, $urandom, $urandom, $urandom);
        else
            send(KIND_ADD, b, $urandom_range(1, MAX_PRIORITY), $urandom);
    endtask

    initial begin
        int bases[9]  = '{2, 1, 16, 3, 0, 31, 5, 4, 2};
        int counts[9] = '{4, 1, 8, 8, 0, 15, 2, 9, 3};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_reg(CFG_QUANTUM_BASE, 2);
        write_reg(CFG_QUEUE_COUNT, 4);
        quiet = 1;
        send(KIND_TICK, 0, 0, 0);
        send(KIND_ADD, 0, 10, 1);
        send(KIND_ADD, 501, 10, 2);
        send(KIND_ADD, 511, 63, 3);
        send(KIND_ADD, 20, 0, 4);
        send(KIND_ADD, 20, 51, 5);
        send(KIND_ADD, 20, 63, 6);
        send(KIND_ADD, 1, 1, 0);
        send(KIND_ADD, MAX_BURST, MAX_PRIORITY, 3);
        send(KIND_ADD, 7, 3, 1);
        send(KIND_ADD, 7, 3, 7);
        repeat (8) send(KIND_TICK, 0, 0, $urandom);
        quiet = 0;
        drain();
        for (int p = 0; p < 9; p++) begin
            write_reg(CFG_QUANTUM_BASE, bases[p]);
            write_reg(CFG_QUEUE_COUNT, counts[p]);
            quiet = ($urandom_range(0, 3) == 0);
            if (p % 2 == 1) begin
                repeat (75) send(KIND_ADD, $urandom_range(1, 6),
                                 $urandom_range(1, MAX_PRIORITY), $urandom);
            end
            repeat (p % 2 == 1 ? 85 : 160) begin
                if ($urandom_range(0, 99) < 40) random_add();
                else send(KIND_TICK, $urandom, $urandom, $urandom);
            end
            drain();
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hdl/mfq_pkg.sv
hdl/mfq_ram.sv
hdl/mfq_ctrl.sv
hdl/mfq_datapath.sv
hdl/multilevel_feedback_queue_scheduler.sv
tb/sv/mfq_checker.sv
tb/sv/tb_top.sv
